@@ rtl/bptf_pkg.sv @@
// Shared constants, types and helpers for the baud-paced transmit FIFO.
package bptf_pkg;

   // Sizing
   localparam int FIFO_DEPTH    = 32;
   localparam int TICKS_PER_SEC = 1000;
   localparam int PTR_W         = $clog2(FIFO_DEPTH);
   localparam int BAUD_W        = 27;
   localparam int QUOTA_W       = 14;
   // five data bits plus start and stop bits; up to eight data and two stop
   localparam int MIN_BITS      = 7;
   localparam int MAX_BITS      = 11;
   localparam int DIV_W         = $clog2(TICKS_PER_SEC * MAX_BITS + 1);
   localparam int ACC_W         = DIV_W + 1;
   localparam int DIVCNT_W      = $clog2(BAUD_W + 1);
   localparam int CSR_IDX_W     = 3;

   localparam logic [QUOTA_W-1:0] QUOTA_MAX = {QUOTA_W{1'b1}};

   // Reset line settings: 9600 baud, 8 data bits, one stop bit
   localparam int RST_BAUD    = 9600;
   localparam int RST_DIVISOR = TICKS_PER_SEC * 10;
   localparam int RST_QUOTA   = RST_BAUD / RST_DIVISOR;
   localparam int RST_STEP    = RST_BAUD % RST_DIVISOR;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] CSR_BAUD_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TWO_STOP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_ENABLE = 3'd4;

   // Request and result codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_TICK = 1'b1;
   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic       accepted;
      logic [7:0] out_byte;
      logic       delivered;
      logic       last;
      logic       fifo_empty;
   } rsp_type;

   // Pacing figures handed from the divider to the drain logic
   typedef struct packed {
      logic [DIV_W-1:0]   divisor;
      logic [QUOTA_W-1:0] quota;
      logic [DIV_W-1:0]   step;
   } rate_type;

   // Ticks per second times bits per character
   function automatic logic [DIV_W-1:0] calc_divisor(input logic [1:0] char_size,
                                                    input logic       two_stop);
      logic [3:0] bits;
      bits = 4'(MIN_BITS) + {2'b00, char_size} + {3'b000, two_stop};
      return DIV_W'(TICKS_PER_SEC * int'(bits));
   endfunction

endpackage

@@ rtl/bptf_fifo_ram.sv @@
// Byte store of the transmit ring: one write port, one registered read port.
module bptf_fifo_ram
   import bptf_pkg::*;
(
   input  logic       clock,
   input  logic       wr_en,
   input  ptr_type    wr_addr,
   input  logic [7:0] wr_data,
   input  logic       rd_en,
   input  ptr_type    rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] mem_ff [FIFO_DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bptf_rate_div.sv @@
// Restoring divider that turns the line settings into per-tick quota and residual step.
module bptf_rate_div
   import bptf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BAUD_W-1:0] baud_rate,
   input  logic [1:0]        char_size,
   input  logic              two_stop,
   output logic              busy,
   output rate_type          rate
);

   logic                busy_ff;
   logic [DIVCNT_W-1:0] cnt_ff;
   logic [BAUD_W-1:0]   dvd_ff;
   logic [BAUD_W-1:0]   quo_ff;
   logic [DIV_W-1:0]    rem_ff;
   logic [DIV_W-1:0]    dsr_ff;
   rate_type            rate_ff;

   logic [DIV_W:0]      trial;
   logic                fits;
   logic [DIV_W-1:0]    rem_in;
   logic [BAUD_W-1:0]   quo_in;
   logic [QUOTA_W-1:0]  quota_in;

   // One quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, dvd_ff[BAUD_W-1]};
      fits     = (trial >= {1'b0, dsr_ff});
      rem_in   = fits ? DIV_W'(trial - {1'b0, dsr_ff}) : trial[DIV_W-1:0];
      quo_in   = {quo_ff[BAUD_W-2:0], fits};
      // quota saturates at the field's limit
      quota_in = (quo_in > BAUD_W'(QUOTA_MAX)) ? QUOTA_MAX : quo_in[QUOTA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rate_ff <= '{divisor: DIV_W'(RST_DIVISOR),
                      quota:   QUOTA_W'(RST_QUOTA),
                      step:    DIV_W'(RST_STEP)};
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIVCNT_W'(BAUD_W);
         dvd_ff  <= baud_rate;
         quo_ff  <= '0;
         rem_ff  <= '0;
         dsr_ff  <= calc_divisor(char_size, two_stop);
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[BAUD_W-2:0], 1'b0};
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIVCNT_W'(1)) begin
            busy_ff <= 1'b0;
            rate_ff <= '{divisor: dsr_ff, quota: quota_in, step: rem_in};
         end
      end
   end

   assign busy = busy_ff;
   assign rate = rate_ff;

endmodule

@@ rtl/baud_paced_tx_fifo.sv @@
// Baud-paced transmit FIFO: top level with CSRs, ring pointers and tick drain sequencer.
// Push: the acknowledge beat is in the result register the cycle after accept.
// Tick sending n bytes: beats go from the registered store read to the result register,
// one per cycle unless the result register stalls; the next item is taken after the last.
// A write to baud_rate, char_size or two_stop holds off items while the divider reruns.
// Synchronous reset: ring empty, accumulator zero, 9600 baud 8N1, tx off, rx on.
module baud_paced_tx_fifo
   import bptf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BAUD_W-1:0]    csr_data
);

   localparam int WANT_W = QUOTA_W + 1;

   function automatic ptr_type next_ptr(input ptr_type p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // CSRs
   logic [BAUD_W-1:0] baud_ff;
   logic [1:0]        char_ff;
   logic              stop_ff;
   logic              txen_ff;
   logic              rxen_ff;
   logic              div_start_ff;
   logic              div_busy;
   rate_type          rate;

   // Ring and pacing state
   ptr_type           wp_ff;
   ptr_type           rp_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [PTR_W-1:0]  rem_ff;

   // Read stage (memory output) and result register
   logic              rd_valid_ff;
   logic              rd_last_ff;
   logic              rd_empty_ff;
   logic [7:0]        rd_data;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              csr_fire;
   logic              busy;
   logic              req_fire;
   logic              push;
   logic              tick;
   ptr_type           wp_next;
   logic              push_ok;
   ptr_type           wp_in;
   logic [PTR_W-1:0]  count;
   logic [ACC_W:0]    sum;
   logic              extra;
   logic [ACC_W-1:0]  acc_in;
   logic [WANT_W-1:0] want;
   logic [PTR_W-1:0]  nsend;
   logic              rd_move;
   logic              rd_en;
   ptr_type           rp_next;

   // CSR write port; divider reruns after any line-setting write
   assign csr_ready = ~(div_start_ff | div_busy);
   assign csr_fire  = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         baud_ff      <= BAUD_W'(RST_BAUD);
         char_ff      <= 2'd3;
         stop_ff      <= 1'b0;
         txen_ff      <= 1'b0;
         rxen_ff      <= 1'b1;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (csr_fire) begin
            case (csr_index)
               CSR_BAUD_RATE: begin
                  baud_ff      <= csr_data;
                  div_start_ff <= 1'b1;
               end
               CSR_CHAR_SIZE: begin
                  char_ff      <= csr_data[1:0];
                  div_start_ff <= 1'b1;
               end
               CSR_TWO_STOP: begin
                  stop_ff      <= csr_data[0];
                  div_start_ff <= 1'b1;
               end
               CSR_TX_ENABLE: txen_ff <= csr_data[0];
               CSR_RX_ENABLE: rxen_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   bptf_rate_div u_rate_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .baud_rate (baud_ff),
      .char_size (char_ff),
      .two_stop  (stop_ff),
      .busy      (div_busy),
      .rate      (rate)
   );

   // Request side: one item at a time; a push needs the result register free
   assign busy      = (rem_ff != '0) | rd_valid_ff | div_start_ff | div_busy;
   assign req_stall = busy | (rsp_valid_ff & rsp_stall);
   assign req_fire  = req_valid & ~req_stall;
   assign push      = req_fire & (req_payload.func == FUNC_PUSH);
   assign tick      = req_fire & (req_payload.func == FUNC_TICK) & txen_ff;

   // Push: one slot kept free to tell full from empty
   assign wp_next = next_ptr(wp_ff);
   assign push_ok = (wp_next != rp_ff);
   assign wp_in   = push_ok ? wp_next : wp_ff;

   // Tick: bytes to send = min(fill, quota + extra byte from the accumulator)
   always_comb begin
      count  = (wp_ff >= rp_ff) ? wp_ff - rp_ff : PTR_W'(FIFO_DEPTH) - rp_ff + wp_ff;
      sum    = {1'b0, acc_ff} + (ACC_W + 1)'(rate.step);
      extra  = (sum >= (ACC_W + 1)'(rate.divisor));
      acc_in = extra ? ACC_W'(sum - (ACC_W + 1)'(rate.divisor)) : sum[ACC_W-1:0];
      want   = {1'b0, rate.quota} + WANT_W'(extra);
      nsend  = (WANT_W'(count) <= want) ? count : want[PTR_W-1:0];
   end

   // Drain: while tick bytes remain, issue a read whenever the read stage is free or moving on
   assign rd_move = rd_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign rd_en   = (rem_ff != '0) & (~rd_valid_ff | rd_move);
   assign rp_next = next_ptr(rp_ff);

   bptf_fifo_ram u_fifo_ram (
      .clock   (clock),
      .wr_en   (push & push_ok),
      .wr_addr (wp_ff),
      .wr_data (req_payload.data_byte),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   // Pointers, accumulator and drain counter
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         acc_ff <= '0;
         rem_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_in;
         end
         if (tick) begin
            acc_ff <= acc_in;
            rem_ff <= nsend;
         end else if (rd_en) begin
            rem_ff <= rem_ff - 1'b1;
         end
         if (rd_en) begin
            rp_ff <= rp_next;
         end
      end
   end

   // Read stage flags travel with the memory data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= 1'b1;
      end else if (rd_move) begin
         rd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_last_ff  <= (rem_ff == PTR_W'(1));
         rd_empty_ff <= (rp_next == wp_ff);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push | rd_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ff <= '{kind: KIND_ACK, accepted: push_ok, out_byte: 8'd0, delivered: 1'b0,
                     last: 1'b1, fifo_empty: (wp_in == rp_ff)};
      end else if (rd_move) begin
         rsp_ff <= '{kind: KIND_BYTE, accepted: 1'b0, out_byte: rd_data, delivered: rxen_ff,
                     last: rd_last_ff, fifo_empty: rd_empty_ff};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The final byte of a tick leaves nothing of that tick behind it
   a_last_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_BYTE && rsp_ff.last)
         |-> (rem_ff == '0 && !rd_valid_ff))
      else $error("bytes still queued after last beat of a tick");

   // A line-setting write holds off items while the divider reruns
   a_div_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && (csr_index == CSR_BAUD_RATE || csr_index == CSR_CHAR_SIZE
                    || csr_index == CSR_TWO_STOP)) |=> req_stall)
      else $error("item taken while pacing figures are being recomputed");

   // Read stage holds its byte while the result register is blocked
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && !rd_move) |=> (rd_valid_ff && $stable(rd_data)))
      else $error("read stage byte lost while stalled");

endmodule
